[src/pwm_prescaler_period_search_macros.svh]
// ----------------------------------------------------------------------------
// pwm_prescaler_period_search_macros
// Assertion macros shared by the PWM prescaler search RTL.
// ----------------------------------------------------------------------------
`ifndef PWM_PRESCALER_PERIOD_SEARCH_MACROS_SVH
`define PWM_PRESCALER_PERIOD_SEARCH_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define PPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants for the PWM prescaler period search block.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Width of the shared divider; covers the widest dividend of the search.
  localparam int DIV_W = 53;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_FREQ = 2'd1;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
  localparam logic [1:0] ST_NO_FIT    = 2'd3;

  localparam logic [DIV_W-1:0] US_PER_S  = DIV_W'(1000000);
  localparam logic [DIV_W-1:0] HALF_MEGA = DIV_W'(500000);

endpackage

[src/pps_divider.sv]
// ----------------------------------------------------------------------------
// pps_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pps_pkg::DIV_W-1:0]  num_i,
  input  logic [pps_pkg::DIV_W-1:0]  den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [pps_pkg::DIV_W-1:0]  quot_o
);

  localparam int W     = pps_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     quot_q, quot_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     den_q, den_d;
  logic [W:0]       rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, quot_q[W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so W bits hold it.
      rem_d  = ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
      quot_d = {quot_q[W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[src/pwm_prescaler_period_search.sv]
// ----------------------------------------------------------------------------
// pwm_prescaler_period_search
// Searches timer prescaler and period settings for a requested PWM signal.
// ----------------------------------------------------------------------------
// A request (frequency, pulse width in microseconds, polarity) is one
// transfer on the input channel; one result transfer follows on the output
// channel. Both channels use valid and ready. The timer clock register is
// written through cfg_we_i and cfg_wdata_i; the user must write it only while
// the block is idle, which the block itself does not enforce.
// Every prescaler is tried in increasing order; each try costs two divisions
// on one shared 53-bit restoring divider. A prescaler whose rounded period is
// out of range costs only the first division. A full search tries 65536
// prescalers; an exact match ends it early. Requests with a zero frequency or
// width are rejected at once, and a too-wide pulse after the division of the
// width check. The compare value adds one more division at the end.
// The block takes one request at a time: input ready is high only while the
// sequencer is idle. A finished result sits in an output register, so a new
// request may be taken while the receiver stalls; the next result then waits
// until the register is free. Reset empties the block and sets the timer
// clock to 32 MHz.
// ----------------------------------------------------------------------------
`include "pwm_prescaler_period_search_macros.svh"

module pwm_prescaler_period_search #(
  parameter int PRESCALER_MAX = 65535,
  parameter int PERIOD_MAX    = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] target_freq_hz_i,
  input  logic [31:0] width_us_i,
  input  logic        polarity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] prescaler_o,
  output logic [15:0] period_reload_o,
  output logic [16:0] compare_value_o,
  output logic [31:0] achieved_freq_hz_o,
  output logic        active_high_o
);

  localparam int W = pps_pkg::DIV_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WCHK   = 4'd1;
  localparam logic [3:0] S_DEN    = 4'd2;
  localparam logic [3:0] S_CNT_GO = 4'd3;
  localparam logic [3:0] S_CNT    = 4'd4;
  localparam logic [3:0] S_PROD   = 4'd5;
  localparam logic [3:0] S_ACT_GO = 4'd6;
  localparam logic [3:0] S_ACT    = 4'd7;
  localparam logic [3:0] S_C1     = 4'd8;
  localparam logic [3:0] S_C2     = 4'd9;
  localparam logic [3:0] S_CMP_GO = 4'd10;
  localparam logic [3:0] S_CMP    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]   state_q, state_d;
  logic [31:0]  clk_hz_q;
  logic [31:0]  freq_q, freq_d;
  logic [31:0]  width_q, width_d;
  logic         pol_q, pol_d;
  logic [1:0]   status_q, status_d;
  logic [15:0]  psc_q, psc_d;
  logic         found_q, found_d;
  logic [15:0]  best_psc_q, best_psc_d;
  logic [16:0]  best_cnt_q, best_cnt_d;
  logic [31:0]  best_act_q, best_act_d;
  logic [31:0]  min_err_q, min_err_d;
  logic [16:0]  cnt_q, cnt_d;
  logic [16:0]  cmp_q, cmp_d;
  logic [W-1:0] mul_q, mul_d;

  logic         out_valid_q;
  logic [1:0]   out_status_q;
  logic [15:0]  out_psc_q;
  logic [15:0]  out_reload_q;
  logic [16:0]  out_cmp_q;
  logic [31:0]  out_act_q;
  logic         out_pol_q;

  logic         div_start;
  logic [W-1:0] div_num, div_den, div_quot;
  logic         div_busy, div_done;

  logic [16:0]  psc_div;
  logic [48:0]  den_prod;
  logic [33:0]  cnt_prod;
  logic [48:0]  c1_prod;
  logic [51:0]  c2_prod;
  logic [31:0]  act;
  logic [31:0]  err;
  logic         out_free;
  logic         last_psc;

  logic         res_ok;
  logic         res_zeroed;
  logic         res_cmp_ok;

  assign psc_div  = {1'b0, psc_q} + 17'd1;
  assign den_prod = 49'(freq_q) * 49'(psc_div);
  assign cnt_prod = 34'(psc_div) * 34'(cnt_q);
  assign c1_prod  = 49'(best_cnt_q) * 49'(best_act_q);
  assign c2_prod  = 52'(mul_q[31:0]) * 52'(width_q[19:0]);
  assign act      = div_quot[31:0];
  assign err      = (act > freq_q) ? (act - freq_q) : (freq_q - act);
  assign out_free = !out_valid_q || out_ready_i;
  assign last_psc = (psc_q == 16'(PRESCALER_MAX));

  // The shared divider serves the width check, the period rounding, the
  // achieved frequency and the compare rounding.
  always_comb begin
    div_start = 1'b0;
    div_num   = W'(clk_hz_q);
    div_den   = mul_q;
    case (state_q)
      S_IDLE: begin
        div_start = in_valid_i && (target_freq_hz_i != '0) && (width_us_i != '0);
        div_num   = pps_pkg::US_PER_S;
        div_den   = W'(target_freq_hz_i);
      end
      S_CNT_GO: begin
        div_start = 1'b1;
        div_num   = W'(clk_hz_q) + (mul_q >> 1);
      end
      S_ACT_GO: begin
        div_start = 1'b1;
      end
      S_CMP_GO: begin
        div_start = 1'b1;
        div_num   = mul_q;
        div_den   = pps_pkg::US_PER_S;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pps_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer. After each prescaler either the next one is tried or the
  // search ends: on an exact match, or after the last prescaler.
  always_comb begin
    state_d    = state_q;
    freq_d     = freq_q;
    width_d    = width_q;
    pol_d      = pol_q;
    status_d   = status_q;
    psc_d      = psc_q;
    found_d    = found_q;
    best_psc_d = best_psc_q;
    best_cnt_d = best_cnt_q;
    best_act_d = best_act_q;
    min_err_d  = min_err_q;
    cnt_d      = cnt_q;
    cmp_d      = cmp_q;
    mul_d      = mul_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          freq_d   = target_freq_hz_i;
          width_d  = width_us_i;
          pol_d    = polarity_i;
          found_d  = 1'b0;
          status_d = pps_pkg::ST_OK;
          if (target_freq_hz_i == '0) begin
            status_d = pps_pkg::ST_ZERO_FREQ;
            state_d  = S_DONE;
          end else if (width_us_i == '0) begin
            status_d = pps_pkg::ST_BAD_WIDTH;
            state_d  = S_DONE;
          end else begin
            state_d = S_WCHK;
          end
        end
      end
      S_WCHK: begin
        if (div_done) begin
          if (W'(width_q) >= div_quot) begin
            status_d = pps_pkg::ST_BAD_WIDTH;
            state_d  = S_DONE;
          end else begin
            psc_d   = '0;
            state_d = S_DEN;
          end
        end
      end
      S_DEN: begin
        mul_d   = W'(den_prod);
        state_d = S_CNT_GO;
      end
      S_CNT_GO: begin
        state_d = S_CNT;
      end
      S_CNT: begin
        if (div_done) begin
          if ((div_quot == '0) || (div_quot > W'(PERIOD_MAX))) begin
            if (last_psc) begin
              status_d = found_q ? pps_pkg::ST_OK : pps_pkg::ST_NO_FIT;
              state_d  = found_q ? S_C1 : S_DONE;
            end else begin
              psc_d   = psc_q + 16'd1;
              state_d = S_DEN;
            end
          end else begin
            cnt_d   = div_quot[16:0];
            state_d = S_PROD;
          end
        end
      end
      S_PROD: begin
        mul_d   = W'(cnt_prod);
        state_d = S_ACT_GO;
      end
      S_ACT_GO: begin
        state_d = S_ACT;
      end
      S_ACT: begin
        if (div_done) begin
          if (!found_q || (err < min_err_q)) begin
            found_d    = 1'b1;
            best_psc_d = psc_q;
            best_cnt_d = cnt_q;
            best_act_d = act;
            min_err_d  = err;
          end
          if ((!found_q || (err < min_err_q)) && (err == '0)) begin
            state_d = S_C1;
          end else if (last_psc) begin
            state_d = S_C1;
          end else begin
            psc_d   = psc_q + 16'd1;
            state_d = S_DEN;
          end
        end
      end
      S_C1: begin
        // Counts times achieved frequency never exceeds the timer clock.
        mul_d   = W'(c1_prod[31:0]);
        state_d = S_C2;
      end
      S_C2: begin
        mul_d   = W'(c2_prod) + pps_pkg::HALF_MEGA;
        state_d = S_CMP_GO;
      end
      S_CMP_GO: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (div_done) begin
          if (div_quot == '0) begin
            cmp_d = 17'd1;
          end else if (div_quot > W'(best_cnt_q)) begin
            cmp_d = best_cnt_q;
          end else begin
            cmp_d = div_quot[16:0];
          end
          status_d = pps_pkg::ST_OK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clk_hz_q    <= 32'd32000000;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        clk_hz_q <= cfg_wdata_i;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    width_q    <= width_d;
    pol_q      <= pol_d;
    status_q   <= status_d;
    psc_q      <= psc_d;
    best_psc_q <= best_psc_d;
    best_cnt_q <= best_cnt_d;
    best_act_q <= best_act_d;
    min_err_q  <= min_err_d;
    cnt_q      <= cnt_d;
    cmp_q      <= cmp_d;
    mul_q      <= mul_d;
    if ((state_q == S_DONE) && out_free) begin
      out_status_q <= status_q;
      out_pol_q    <= pol_q;
      if (status_q == pps_pkg::ST_OK) begin
        out_psc_q    <= best_psc_q;
        out_reload_q <= 16'(best_cnt_q - 17'd1);
        out_cmp_q    <= cmp_q;
        out_act_q    <= best_act_q;
      end else begin
        out_psc_q    <= '0;
        out_reload_q <= '0;
        out_cmp_q    <= '0;
        out_act_q    <= '0;
      end
    end
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign prescaler_o        = out_psc_q;
  assign period_reload_o    = out_reload_q;
  assign compare_value_o    = out_cmp_q;
  assign achieved_freq_hz_o = out_act_q;
  assign active_high_o      = out_pol_q;

  // Result properties checked by the assertions below.
  assign res_ok     = out_valid_o && (status_o == pps_pkg::ST_OK);
  assign res_zeroed = (prescaler_o == '0) && (compare_value_o == '0) &&
                      (achieved_freq_hz_o == '0);
  assign res_cmp_ok = (compare_value_o != '0) &&
                      (compare_value_o <= ({1'b0, period_reload_o} + 17'd1));

  `PPS_ASSERT(a_start_idle_div, div_start |-> !div_busy, "divider started while busy")
  `PPS_ASSERT(a_fail_zero, (out_valid_o && !res_ok) |-> res_zeroed, "failed result carries settings")
  `PPS_ASSERT(a_ok_cmp, res_ok |-> res_cmp_ok, "compare value out of range")
  `PPS_ASSERT_NEVER(a_done_idle, div_done && (state_q == S_IDLE), "divider finished while idle")

endmodule
